// ===== design/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg : shared types and codes for the integer stack with cursor
// Transaction payloads, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

   // default number of stack entries
   localparam int unsigned DEPTH_DEFAULT = 1024;

   // width of the position fields in a response
   localparam int unsigned POS_OUT_W = 11;

   // operation codes carried in the mode field
   typedef enum logic [3:0] {
      MODE_PUSH      = 4'd0,
      MODE_POP       = 4'd1,
      MODE_READ_DOWN = 4'd2,
      MODE_READ_UP   = 4'd3,
      MODE_CUR_TOP   = 4'd4,
      MODE_CUR_BOT   = 4'd5,
      MODE_SWAP      = 4'd6,
      MODE_SRCH_DOWN = 4'd7,
      MODE_BIN_SRCH  = 4'd8,
      MODE_REVERSE   = 4'd9
   } mode_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SRCH_ISSUE,
      ST_SRCH_CHECK,
      ST_BIN_ISSUE,
      ST_BIN_CHECK,
      ST_XCH_RDA,
      ST_XCH_RDB,
      ST_XCH_WRA,
      ST_XCH_WRB,
      ST_FINISH
   } state_type;

   // request transaction
   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] value;
   } req_type;

   // response transaction
   typedef struct packed {
      logic                 ok;
      logic signed [31:0]   read_value;
      logic [POS_OUT_W-1:0] cursor_pos;
      logic [POS_OUT_W-1:0] fill_level;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/isc_ram.sv =====
// ----------------------------------------------------------------------------
// isc_ram : stack word store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_ram #(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [31:0]                wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [31:0]                rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/integer_stack_with_cursor_core.sv =====
// ----------------------------------------------------------------------------
// integer_stack_with_cursor_core : stack of signed words with a read cursor
// Push, pop, cursor reads and moves, swap, linear and binary search and
// in-place reversal, run by a small sequencer around one word store.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_data  (req_type)
//   rsp      out        rsp_valid / rsp_ready     rsp_data  (rsp_type)
//
// Push, cursor moves, unused modes and refused pops, reads or swaps run EXEC
// then FINISH; pop and reads add READ. Swap and each reversal pair run the
// XCH_RDA, XCH_RDB, XCH_WRA, XCH_WRB states. Search down and binary search run
// ISSUE, CHECK per entry or probe: one store access, then its registered data.
// req_ready is high only when idle; a response waiting in the output register
// lets the next transaction run. Reset clears fill and cursor, not the store.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_stack_with_cursor_core
   import isc_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned PW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

   // sequencer and datapath registers
   state_type          state_ff, state_in;
   logic [3:0]         mode_ff, mode_in;
   logic signed [31:0] key_ff, key_in;
   logic [PW-1:0]      top_ff, top_in;
   logic [PW-1:0]      cur_ff, cur_in;
   logic [PW-1:0]      pa_ff, pa_in;
   logic [PW-1:0]      pb_ff, pb_in;
   logic [PW-1:0]      mid_ff, mid_in;
   logic [31:0]        held_ff, held_in;
   logic               ok_ff, ok_in;
   logic [31:0]        rd_ff, rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // store port
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [31:0]   ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;

   // shared helpers
   logic [PW-1:0] top_m1;
   logic [PW-1:0] cur_m1;
   logic [PW-1:0] pa_p1;
   logic [PW-1:0] pb_m1;
   logic [PW-1:0] mid_calc;
   logic          key_eq;
   logic          key_lt;
   logic          rsp_free;

   assign top_m1   = top_ff - PW'(1);
   assign cur_m1   = cur_ff - PW'(1);
   assign pa_p1    = pa_ff + PW'(1);
   assign pb_m1    = pb_ff - PW'(1);
   assign mid_calc = pa_ff + ((pb_ff - PW'(1) - pa_ff) >> 1);

   // the one compare unit: key against the word just read
   assign key_eq = (ram_rd_data == key_ff);
   assign key_lt = (key_ff < $signed(ram_rd_data));

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   isc_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      key_ff  <= key_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      mid_ff  <= mid_in;
      held_ff <= held_in;
      ok_ff   <= ok_in;
      rd_ff   <= rd_in;
      rsp_ff  <= rsp_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      top_in       = top_ff;
      cur_in       = cur_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      mid_in       = mid_ff;
      held_in      = held_ff;
      ok_in        = ok_ff;
      rd_in        = rd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_data.mode;
               key_in   = req_data.value;
               ok_in    = 1'b0;
               rd_in    = '0;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_FINISH;
            unique case (mode_ff)
               MODE_PUSH: begin
                  if (top_ff < DEPTH_P) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = top_ff[AW-1:0];
                     ram_wr_data = key_ff;
                     top_in      = top_ff + PW'(1);
                     ok_in       = 1'b1;
                  end
               end
               MODE_POP: begin
                  if (top_ff != '0) begin
                     top_in      = top_m1;
                     ram_rd_addr = top_m1[AW-1:0];
                     ok_in       = 1'b1;
                     state_in    = ST_READ;
                  end
               end
               MODE_READ_DOWN: begin
                  if (cur_ff != '0) begin
                     cur_in      = cur_m1;
                     ram_rd_addr = cur_m1[AW-1:0];
                     ok_in       = 1'b1;
                     state_in    = ST_READ;
                  end
               end
               MODE_READ_UP: begin
                  if (cur_ff < top_ff) begin
                     ram_rd_addr = cur_ff[AW-1:0];
                     cur_in      = cur_ff + PW'(1);
                     ok_in       = 1'b1;
                     state_in    = ST_READ;
                  end
               end
               MODE_CUR_TOP: begin
                  cur_in = top_ff;
                  ok_in  = 1'b1;
               end
               MODE_CUR_BOT: begin
                  cur_in = '0;
                  ok_in  = 1'b1;
               end
               MODE_SWAP: begin
                  if (cur_ff < top_ff) begin
                     pa_in    = cur_ff;
                     pb_in    = top_m1;
                     ok_in    = 1'b1;
                     state_in = ST_XCH_RDA;
                  end
               end
               MODE_SRCH_DOWN: begin
                  state_in = ST_SRCH_ISSUE;
               end
               MODE_BIN_SRCH: begin
                  pa_in    = '0;
                  pb_in    = top_ff;
                  state_in = ST_BIN_ISSUE;
               end
               MODE_REVERSE: begin
                  if (top_ff != '0) begin
                     ok_in = 1'b1;
                     pa_in = '0;
                     pb_in = top_m1;
                     if (top_m1 != '0) begin
                        state_in = ST_XCH_RDA;
                     end
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         // word from pop or cursor read arrives
         ST_READ: begin
            rd_in    = ram_rd_data;
            state_in = ST_FINISH;
         end

         // linear search: step the cursor down, then compare
         ST_SRCH_ISSUE: begin
            if (cur_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cur_in      = cur_m1;
               ram_rd_addr = cur_m1[AW-1:0];
               state_in    = ST_SRCH_CHECK;
            end
         end

         ST_SRCH_CHECK: begin
            if (key_eq) begin
               ok_in    = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SRCH_ISSUE;
            end
         end

         // binary search over the half-open range [pa, pb)
         ST_BIN_ISSUE: begin
            if (pa_ff < pb_ff) begin
               mid_in      = mid_calc;
               ram_rd_addr = mid_calc[AW-1:0];
               state_in    = ST_BIN_CHECK;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_BIN_CHECK: begin
            priority if (key_eq) begin
               cur_in   = mid_ff;
               ok_in    = 1'b1;
               state_in = ST_FINISH;
            end else if (key_lt) begin
               pb_in    = mid_ff;
               state_in = ST_BIN_ISSUE;
            end else begin
               pa_in    = mid_ff + PW'(1);
               state_in = ST_BIN_ISSUE;
            end
         end

         // exchange of entries pa and pb, shared by swap and reverse
         ST_XCH_RDA: begin
            ram_rd_addr = pa_ff[AW-1:0];
            state_in    = ST_XCH_RDB;
         end

         ST_XCH_RDB: begin
            ram_rd_addr = pb_ff[AW-1:0];
            held_in     = ram_rd_data;
            state_in    = ST_XCH_WRA;
         end

         ST_XCH_WRA: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pa_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
            state_in    = ST_XCH_WRB;
         end

         ST_XCH_WRB: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pb_ff[AW-1:0];
            ram_wr_data = held_ff;
            state_in    = ST_FINISH;
            if (mode_ff == MODE_REVERSE) begin
               pa_in = pa_p1;
               pb_in = pb_m1;
               if (pa_p1 < pb_m1) begin
                  state_in = ST_XCH_RDA;
               end
            end
         end

         // hand the response to the output register once it is free
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = ok_ff;
               rsp_in.read_value  = rd_ff;
               rsp_in.cursor_pos  = POS_OUT_W'(cur_ff);
               rsp_in.fill_level  = POS_OUT_W'(top_ff);
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // fill level never passes the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= DEPTH_P)
      else $error("fill level beyond capacity");

   // an accepted transaction always starts execution next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction not executed");

   // every store write lands below the fill level
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (PW'($past(ram_wr_addr)) < top_ff))
      else $error("store write above fill level");

   // the store is written only by push and the exchange sequence
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_EXEC || state_ff == ST_XCH_WRA ||
                     state_ff == ST_XCH_WRB))
      else $error("store written outside push or exchange");

   // the binary search range stays inside the stack
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BIN_ISSUE) |-> (pb_ff <= top_ff))
      else $error("binary search range beyond fill level");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_integer_stack_with_cursor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_stack_with_cursor_core : self-checking bench for the cursor stack
// Drives push, pop, cursor reads and moves, swap, searches and reversal
// through the request channel with random gaps and response stalls. A
// scoreboard keeps its own copy of the stack and cursor, predicts one
// response per request and checks each response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_integer_stack_with_cursor_core;
   import isc_pkg::*;

   localparam int unsigned STACK_DEPTH = DEPTH_DEFAULT;
   localparam int unsigned HALF_PERIOD = 6;

   // mode codes with no operation behind them
   localparam logic [3:0] FIRST_SPARE_MODE = 4'd10;
   localparam logic [3:0] LAST_SPARE_MODE  = 4'd15;

   // receiver hold-off used to back the block up
   localparam int unsigned HOLD_CYCLES = 150;

   // ------------------------------------------------------------------------
   // Scoreboard: mirror of the stack, cursor and fill, plus a queue of the
   // responses still owed by the block.
   // ------------------------------------------------------------------------
   class stack_scoreboard;
      bit signed [31:0] words [STACK_DEPTH];
      int unsigned      fill;
      int unsigned      cur;
      rsp_type          owed_q [$];
      int unsigned      errors;

      function new();
         foreach (words[i]) words[i] = '0;
         fill   = 0;
         cur    = 0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      // work out the response of one accepted request
      function void note_request(req_type r);
         bit signed [31:0] key;
         bit signed [31:0] rd;
         bit signed [31:0] w;
         bit               ok_flag;
         int unsigned      lo, hi, mid, b, t;
         rsp_type          owed;
         key     = r.value;
         rd      = '0;
         ok_flag = 1'b0;
         case (r.mode)
            MODE_PUSH: begin
               if (fill < STACK_DEPTH) begin
                  words[fill] = key;
                  fill++;
                  ok_flag = 1'b1;
               end
            end
            MODE_POP: begin
               if (fill > 0) begin
                  fill--;
                  rd      = words[fill];
                  ok_flag = 1'b1;
               end
            end
            MODE_READ_DOWN: begin
               if (cur > 0) begin
                  cur--;
                  rd      = words[cur];
                  ok_flag = 1'b1;
               end
            end
            MODE_READ_UP: begin
               if (cur < fill) begin
                  rd = words[cur];
                  cur++;
                  ok_flag = 1'b1;
               end
            end
            MODE_CUR_TOP: begin
               cur     = fill;
               ok_flag = 1'b1;
            end
            MODE_CUR_BOT: begin
               cur     = 0;
               ok_flag = 1'b1;
            end
            MODE_SWAP: begin
               if (cur < fill) begin
                  w                 = words[cur];
                  words[cur]        = words[fill - 1];
                  words[fill - 1]   = w;
                  ok_flag           = 1'b1;
               end
            end
            MODE_SRCH_DOWN: begin
               while (cur > 0 && !ok_flag) begin
                  cur--;
                  if (words[cur] == key) ok_flag = 1'b1;
               end
            end
            MODE_BIN_SRCH: begin
               // half-open range, signed compare
               lo = 0;
               hi = fill;
               while (lo < hi && !ok_flag) begin
                  mid = lo + ((hi - 1 - lo) >> 1);
                  w   = words[mid];
                  if (w == key) begin
                     cur     = mid;
                     ok_flag = 1'b1;
                  end else if (key < w) begin
                     hi = mid;
                  end else begin
                     lo = mid + 1;
                  end
               end
            end
            MODE_REVERSE: begin
               if (fill > 0) begin
                  b = 0;
                  t = fill - 1;
                  while (t > b) begin
                     w        = words[t];
                     words[t] = words[b];
                     words[b] = w;
                     t--;
                     b++;
                  end
                  ok_flag = 1'b1;
               end
            end
            default: begin
            end
         endcase
         owed.ok         = ok_flag;
         owed.read_value = rd;
         owed.cursor_pos = cur[POS_OUT_W-1:0];
         owed.fill_level = fill[POS_OUT_W-1:0];
         owed_q.push_back(owed);
      endfunction

      // compare one accepted response against the oldest owed one
      function void check_response(rsp_type got);
         rsp_type owed;
         if (owed_q.size() == 0) begin
            $error("response with nothing owed: ok %0d read_value %0d cursor %0d fill %0d",
                   got.ok, got.read_value, got.cursor_pos, got.fill_level);
            errors++;
            return;
         end
         owed = owed_q.pop_front();
         if (got.ok !== owed.ok) begin
            $error("ok: expected %0d, actual %0d", owed.ok, got.ok);
            errors++;
         end
         if (got.read_value !== owed.read_value) begin
            $error("read_value: expected %0d, actual %0d", owed.read_value, got.read_value);
            errors++;
         end
         if (got.cursor_pos !== owed.cursor_pos) begin
            $error("cursor_pos: expected %0d, actual %0d", owed.cursor_pos, got.cursor_pos);
            errors++;
         end
         if (got.fill_level !== owed.fill_level) begin
            $error("fill_level: expected %0d, actual %0d", owed.fill_level, got.fill_level);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   stack_scoreboard sb = new();

   int unsigned req_calm = 0;
   int unsigned rsp_calm = 0;
   int unsigned taken    = 0;

   integer_stack_with_cursor_core #(
      .DEPTH (STACK_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // drawn wait before a transaction, with occasional runs of back-to-back transactions
   function automatic int unsigned draw_wait(ref int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(15, 40);
      return $urandom_range(0, 4);
   endfunction

   // data word, biased towards the extremes
   function automatic logic signed [31:0] draw_word();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0000_0000;
         3: return -32'sd1;
         4: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
         default: return $signed($urandom());
      endcase
   endfunction

   // search key: often a word already on the stack
   function automatic logic signed [31:0] draw_key();
      if (sb.fill > 0 && $urandom_range(0, 2) != 0)
         return sb.words[$urandom_range(0, sb.fill - 1)];
      return draw_word();
   endfunction

   // general mixed request
   function automatic req_type random_op();
      req_type     r;
      int unsigned pick;
      pick    = $urandom_range(0, 99);
      r.value = draw_word();
      if (pick < 30)      r.mode = MODE_PUSH;
      else if (pick < 44) r.mode = MODE_POP;
      else if (pick < 54) r.mode = MODE_READ_DOWN;
      else if (pick < 64) r.mode = MODE_READ_UP;
      else if (pick < 70) r.mode = MODE_CUR_TOP;
      else if (pick < 75) r.mode = MODE_CUR_BOT;
      else if (pick < 81) r.mode = MODE_SWAP;
      else if (pick < 88) r.mode = MODE_SRCH_DOWN;
      else if (pick < 93) r.mode = MODE_BIN_SRCH;
      else if (pick < 97) r.mode = MODE_REVERSE;
      else                r.mode = 4'($urandom_range(FIRST_SPARE_MODE, LAST_SPARE_MODE));
      if (r.mode == MODE_SRCH_DOWN || r.mode == MODE_BIN_SRCH) r.value = draw_key();
      return r;
   endfunction

   // short operations sprinkled into the fill-up run
   function automatic req_type filler_op();
      req_type r;
      r.value = draw_key();
      case ($urandom_range(0, 6))
         0: r.mode = MODE_READ_DOWN;
         1: r.mode = MODE_READ_UP;
         2: r.mode = MODE_CUR_TOP;
         3: r.mode = MODE_CUR_BOT;
         4: r.mode = MODE_SWAP;
         5: r.mode = MODE_BIN_SRCH;
         default: r.mode = 4'($urandom_range(FIRST_SPARE_MODE, LAST_SPARE_MODE));
      endcase
      return r;
   endfunction

   // offer one request; entered and left just after a falling edge
   task automatic send_item(input logic [3:0] mode, input logic signed [31:0] value);
      int unsigned gap;
      req_type     r;
      r.mode  = mode;
      r.value = value;
      gap     = draw_wait(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_req(input req_type r);
      send_item(r.mode, r.value);
   endtask

   // stop offering and wait for every owed response
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // take one response, after a drawn stall or a long hold-off
   task automatic take_response();
      int unsigned stall;
      if (taken == 60 || taken == 700) stall = HOLD_CYCLES;
      else stall = draw_wait(rsp_calm);
      if (stall != 0) begin
         rsp_ready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
      rsp_ready <= 1'b1;
      @(posedge clock);
      while (!rsp_valid) @(posedge clock);
      sb.check_response(rsp_data);
      taken++;
      @(negedge clock);
   endtask

   // receiver
   initial begin
      rsp_ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever take_response();
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus
   initial begin
      longint           run;
      logic signed [31:0] key;
      int unsigned      n;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // operations on the empty stack
      send_item(MODE_POP, 0);
      send_item(MODE_READ_DOWN, 0);
      send_item(MODE_READ_UP, 0);
      send_item(MODE_SWAP, 0);
      send_item(MODE_SRCH_DOWN, 0);
      send_item(MODE_BIN_SRCH, 0);
      send_item(MODE_REVERSE, 0);
      send_item(LAST_SPARE_MODE, -32'sd1);
      // sorted extremes, then searches on them
      send_item(MODE_PUSH, 32'sh8000_0000);
      send_item(MODE_PUSH, -32'sd1);
      send_item(MODE_PUSH, 32'sd0);
      send_item(MODE_PUSH, 32'sd1);
      send_item(MODE_PUSH, 32'sh7fff_ffff);
      send_item(MODE_BIN_SRCH, -32'sd1);
      send_item(MODE_BIN_SRCH, 32'sd5);
      send_item(MODE_CUR_TOP, 0);
      send_item(MODE_READ_UP, 0);
      send_item(MODE_READ_DOWN, 0);
      send_item(MODE_SRCH_DOWN, 32'sh8000_0000);
      send_item(MODE_READ_UP, 0);
      send_item(MODE_SWAP, 0);
      send_item(MODE_REVERSE, 0);
      // cursor left above the top reads a popped word
      send_item(MODE_CUR_TOP, 0);
      send_item(MODE_POP, 0);
      send_item(MODE_READ_DOWN, 0);
      send_item(MODE_SRCH_DOWN, 32'sd12345);
      send_item(FIRST_SPARE_MODE, 32'sh7fff_ffff);
      send_item(MODE_CUR_BOT, 0);

      // mixed traffic on a small stack
      repeat (60) send_req(random_op());

      // pause until everything is back, then rebuild a sorted stack
      drain();
      while (sb.fill > 0) send_item(MODE_POP, 0);
      run = -longint'($urandom_range(0, 32'h4000_0000));
      n   = $urandom_range(30, 50);
      repeat (n) begin
         send_item(MODE_PUSH, 32'(run));
         run += $urandom_range(0, 32'h0100_0000);
      end
      repeat (60) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: key = sb.words[$urandom_range(0, sb.fill - 1)];
            6, 7: key = sb.words[$urandom_range(0, sb.fill - 1)] + 32'sd1;
            default: key = draw_word();
         endcase
         send_item(MODE_BIN_SRCH, key);
         if ($urandom_range(0, 3) == 0) send_item(MODE_READ_UP, 0);
      end

      // fill to the limit, then push on a full stack
      while (sb.fill < STACK_DEPTH) begin
         if ($urandom_range(0, 99) < 92) send_item(MODE_PUSH, draw_word());
         else send_req(filler_op());
      end
      repeat (3) send_item(MODE_PUSH, draw_word());

      // long walks over the full stack
      send_item(MODE_CUR_TOP, 0);
      send_item(MODE_SRCH_DOWN, $signed($urandom()));
      send_item(MODE_REVERSE, 0);
      send_item(MODE_BIN_SRCH, draw_key());
      send_item(MODE_READ_UP, 0);
      send_item(MODE_SWAP, 0);
      send_item(MODE_CUR_TOP, 0);
      send_item(MODE_READ_DOWN, 0);
      send_item(MODE_SRCH_DOWN, draw_key());
      repeat (40) send_req(random_op());

      // let everything come back, then allow for stray responses
      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
design/isc_pkg.sv
design/isc_ram.sv
design/integer_stack_with_cursor_core.sv
tb/tb_integer_stack_with_cursor_core.sv
